// ===== src/fdf_pkg.sv =====
package fdf_pkg;

   // Transaction field widths
   localparam int unsigned ADDR_W = 64;
   localparam int unsigned LEN_W  = 7;

   // Packed channel widths, padded to whole bytes
   localparam int unsigned REQ_DATA_W = ((ADDR_W + LEN_W + 7) / 8) * 8;
   localparam int unsigned RSP_DATA_W = 8;

   // Reset value of the packet length register
   localparam logic [LEN_W-1:0] PKT_LEN_RESET = 7'd16;

   // tuser codes for a request
   localparam logic ACT_FRAME = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SEARCH
   } state_type;

endpackage

// ===== src/fdf_table.sv =====
module fdf_table
   import fdf_pkg::*;
#(
   parameter int unsigned DEPTH  = 128,
   parameter int unsigned ADDR_W_T = 7
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W_T-1:0] wr_addr,
   input  logic [ADDR_W-1:0]   wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W_T-1:0] rd_addr,
   output logic [ADDR_W-1:0]   rd_data
);

   logic [ADDR_W-1:0] mem [DEPTH];
   logic [ADDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fdf_ctrl.sv =====
module fdf_ctrl
   import fdf_pkg::*;
#(
   parameter int unsigned DEPTH    = 128,
   parameter int unsigned ADDR_W_T = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   // request
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]            req_tuser,
   // result
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // packet length register
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LEN_W-1:0]      csr_data,
   // table port
   output logic                  wr_en,
   output logic [ADDR_W_T-1:0]   wr_addr,
   output logic [ADDR_W-1:0]     wr_data,
   output logic                  rd_en,
   output logic [ADDR_W_T-1:0]   rd_addr,
   input  logic [ADDR_W-1:0]     rd_data
);

   localparam logic [ADDR_W_T-1:0] LAST_SLOT = ADDR_W_T'(DEPTH - 1);

   state_type state_ff, state_in;

   logic [ADDR_W_T-1:0] fill_ff, fill_in;
   logic [ADDR_W_T-1:0] idx_ff, idx_in;
   logic                rd_pend_ff, rd_pend_in;
   logic                rd_last_ff, rd_last_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [LEN_W-1:0]    pkt_len_ff, pkt_len_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                fwd_ff, fwd_in;
   logic                dup_ff, dup_in;

   logic              accept, is_tick, len_ok, rsp_free;
   logic              search_start, direct_store, issue, hit, miss_done, store;
   logic [ADDR_W-1:0] in_addr;
   logic [LEN_W-1:0]  in_len;
   logic              wrap;

   assign in_addr = req_tdata[ADDR_W-1:0];
   assign in_len  = req_tdata[ADDR_W+LEN_W-1:ADDR_W];
   assign is_tick = (req_tuser[0] == ACT_TICK);
   assign len_ok  = (in_len == pkt_len_ff);

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;

   assign search_start = accept && !is_tick && len_ok && (fill_ff != '0);
   assign direct_store = accept && !is_tick && len_ok && (fill_ff == '0);

   // compare stage: data of the read issued last cycle
   assign hit       = (state_ff == ST_SEARCH) && rd_pend_ff && (rd_data == addr_ff);
   assign miss_done = (state_ff == ST_SEARCH) && rd_pend_ff && rd_last_ff && !hit;
   assign issue     = (state_ff == ST_SEARCH) && (idx_ff != fill_ff) && !hit;
   assign store     = direct_store || miss_done;
   assign wrap      = (fill_ff >= LAST_SLOT);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (search_start) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hit || miss_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE) && rsp_free;
      csr_ready  = 1'b1;
      rd_en      = issue;
      rd_addr    = idx_ff;
      wr_en      = store;
      wr_addr    = wrap ? '0 : fill_ff;
      wr_data    = direct_store ? in_addr : addr_ff;
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = RSP_DATA_W'({dup_ff, fwd_ff});
   end

   // datapath next values
   always_comb begin
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      rd_pend_in   = issue;
      rd_last_in   = issue && (idx_ff == fill_ff - ADDR_W_T'(1));
      addr_in      = addr_ff;
      pkt_len_in   = pkt_len_ff;
      rsp_valid_in = rsp_valid_ff;
      fwd_in       = fwd_ff;
      dup_in       = dup_ff;

      if (csr_valid && csr_ready) begin
         pkt_len_in = csr_data;
      end

      if (accept) begin
         addr_in = in_addr;
      end

      if (search_start) begin
         idx_in = '0;
      end else if (issue) begin
         idx_in = idx_ff + ADDR_W_T'(1);
      end

      if (accept && is_tick) begin
         fill_in = '0;
      end else if (store) begin
         fill_in = wrap ? ADDR_W_T'(1) : fill_ff + ADDR_W_T'(1);
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && !search_start) begin
         rsp_valid_in = 1'b1;
         fwd_in       = direct_store;
         dup_in       = 1'b0;
      end else if (hit || miss_done) begin
         rsp_valid_in = 1'b1;
         fwd_in       = miss_done;
         dup_in       = hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rd_last_ff   <= 1'b0;
         pkt_len_ff   <= PKT_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_pend_ff   <= rd_pend_in;
         rd_last_ff   <= rd_last_in;
         pkt_len_ff   <= pkt_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      addr_ff <= addr_in;
      fwd_ff  <= fwd_in;
      dup_ff  <= dup_in;
   end

endmodule

// ===== src/flood_duplicate_filter.sv =====
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tdata: origin_address, frame_length; tuser: action
// rsp_      out  rsp_tvalid/rsp_tready  tdata: forward, duplicate
// csr_      in   csr_valid/csr_ready    csr_data: packet_length
//
// A tick, a length mismatch or a packet into an empty table is answered without a scan.
// Otherwise the seen table (one single-port-read RAM with a registered read) is
// scanned one entry per cycle up to the fill count; a hit ends the scan early.
// One transaction is in flight at a time.
// Reset (synchronous) clears fill_count and loads packet_length = 16; table
// contents are left as is. req_tready is low during a scan and while a result
// waits in the output register without rsp_tready.
module flood_duplicate_filter
   import fdf_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 128
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [63:0] origin_address, [70:64] frame_length, [71] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] action (0 frame, 1 periodic send tick)
   input  logic [0:0]            req_tuser,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] forward, [1] duplicate, [7:2] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   // [6:0] packet_length
   input  logic [LEN_W-1:0]      csr_data
);

   // slot index width; fill count never exceeds TABLE_DEPTH-1
   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [ADDR_W-1:0] wr_data, rd_data;

   // scan sequencer, fill count, packet length register, result register
   fdf_ctrl #(
      .DEPTH    (TABLE_DEPTH),
      .ADDR_W_T (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   // seen origin addresses; writes land only outside a scan or as it ends, so no forwarding
   fdf_table #(
      .DEPTH    (TABLE_DEPTH),
      .ADDR_W_T (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== src/fdf_checker.sv =====
module fdf_checker
   import fdf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [0:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a result is never both forward and duplicate
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("forward and duplicate both set");

   // no result pending right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a tick transaction answers next cycle with an empty result
   a_tick: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == ACT_TICK)
      |=> (rsp_tvalid && rsp_tdata[1:0] == 2'b00))
      else $error("tick result missing or nonzero");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind flood_duplicate_filter fdf_checker u_fdf_checker (.*);

// ===== tb/sv/flood_duplicate_filter_checker.sv =====
`timescale 1ns / 1ps

module flood_duplicate_filter_checker
   import fdf_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 128
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]            req_tuser,

   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [LEN_W-1:0]      csr_data,

   output int unsigned           outstanding,
   output int unsigned           failures
);

   localparam int unsigned FORWARD_BIT   = 0;
   localparam int unsigned DUPLICATE_BIT = 1;
   localparam int unsigned REPORT_LIMIT  = 10;

   typedef struct packed {
      logic forward;
      logic duplicate;
   } filter_decision_type;

   // private copy of the filter state
   logic [ADDR_W-1:0] seen_addr [TABLE_DEPTH];
   int unsigned       seen_fill;
   logic [LEN_W-1:0]  match_len;

   filter_decision_type decisions_due [$];
   int unsigned         mismatch_total;

   initial begin
      outstanding    = 0;
      failures       = 0;
      mismatch_total = 0;
      seen_fill      = 0;
      match_len      = PKT_LEN_RESET;
   end

   // Updates the copy of the table and returns the decision for one transaction.
   function automatic filter_decision_type decide_frame(input logic act,
                                                        input logic [ADDR_W-1:0] addr,
                                                        input logic [LEN_W-1:0] len);
      filter_decision_type d;
      logic                hit;
      int unsigned         i;
      d   = '0;
      hit = 1'b0;
      if (act == ACT_TICK) begin
         seen_fill = 0;
         return d;
      end
      if (len != match_len)
         return d;
      for (i = 0; i < seen_fill; i++)
         if (seen_addr[i] == addr)
            hit = 1'b1;
      if (hit) begin
         d.duplicate = 1'b1;
      end else begin
         if (seen_fill >= TABLE_DEPTH - 1)
            seen_fill = 0;
         seen_addr[seen_fill] = addr;
         seen_fill++;
         d.forward = 1'b1;
      end
      return d;
   endfunction

   task automatic flag_failure(input string what, input filter_decision_type want,
                               input filter_decision_type got);
      mismatch_total++;
      if (mismatch_total <= REPORT_LIMIT)
         $display("%0t: %s: expected forward=%0b duplicate=%0b, got forward=%0b duplicate=%0b",
                  $realtime, what, want.forward, want.duplicate, got.forward, got.duplicate);
   endtask

   always @(posedge clock) begin
      filter_decision_type want;
      filter_decision_type got;
      if (reset) begin
         seen_fill = 0;
         match_len = PKT_LEN_RESET;
         decisions_due.delete();
      end else begin
         if (csr_valid && csr_ready)
            match_len = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.forward   = rsp_tdata[FORWARD_BIT];
            got.duplicate = rsp_tdata[DUPLICATE_BIT];
            if (decisions_due.size() == 0) begin
               flag_failure("result with no transaction pending", '0, got);
            end else begin
               want = decisions_due.pop_front();
               if (got.forward !== want.forward || got.duplicate !== want.duplicate)
                  flag_failure("result mismatch", want, got);
            end
         end
         if (req_tvalid && req_tready)
            decisions_due.push_back(decide_frame(req_tuser[0], req_tdata[ADDR_W-1:0],
                                                 req_tdata[ADDR_W +: LEN_W]));
      end
      outstanding <= decisions_due.size();
      failures    <= mismatch_total;
   end

endmodule

// ===== tb/sv/tb_flood_duplicate_filter.sv =====
`timescale 1ns / 1ps

module tb_flood_duplicate_filter
   import fdf_pkg::*;
();

   localparam int unsigned TABLE_DEPTH    = 128;
   // worst case is a full table scan plus stalls on either side
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned SETTLE_CYCLES  = TABLE_DEPTH + 8;
   localparam int unsigned POOL_SIZE      = 16;
   localparam int unsigned BURST_LEN      = 140;   // enough fresh stores to wrap the table
   localparam int unsigned PHASE_ITEMS    = 160;

   localparam logic [ADDR_W-1:0] ADDR_ZERO = '0;
   localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
   localparam logic [ADDR_W-1:0] ADDR_ALTA = {16{4'hA}};
   localparam logic [ADDR_W-1:0] ADDR_ALT5 = {16{4'h5}};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [63:0] origin_address, [70:64] frame_length, [71] zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // [0] action
   logic [0:0]            req_tuser  = ACT_FRAME;

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [0] forward, [1] duplicate, [7:2] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   // [6:0] packet_length
   logic [LEN_W-1:0]      csr_data   = PKT_LEN_RESET;

   int unsigned           outstanding;
   int unsigned           failures;

   // idle percentages for the sending side and the receiving side
   int unsigned           send_gap_pct = 0;
   int unsigned           stall_pct    = 0;
   int unsigned           quiet_cycles = 0;

   // packet length the stimulus currently aims at
   logic [LEN_W-1:0]      cur_len = PKT_LEN_RESET;
   // recently seen origins, reused so that duplicates are common
   logic [ADDR_W-1:0]     addr_pool  [POOL_SIZE];
   logic [ADDR_W-1:0]     burst_addr [BURST_LEN];

   initial begin
      forever #5 clock = ~clock;
   end

   flood_duplicate_filter #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   flood_duplicate_filter_checker #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .failures    (failures)
   );

   // Receiver: random backpressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: any transaction on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [ADDR_W-1:0] fresh_addr();
      return {$urandom(), $urandom()};
   endfunction

   // 0: sender idles 13%, receiver 62%; 1: the other way round; 2: no idling
   task automatic set_idling(input int unsigned mode);
      case (mode)
         0: begin
            send_gap_pct = 13;
            stall_pct    = 62;
         end
         1: begin
            send_gap_pct = 62;
            stall_pct    = 13;
         end
         default: begin
            send_gap_pct = 0;
            stall_pct    = 0;
         end
      endcase
   endtask

   // One request transaction. valid stays up into the next item unless a gap is drawn.
   task automatic send_item(input logic act, input logic [ADDR_W-1:0] addr,
                            input logic [LEN_W-1:0] len);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(REQ_DATA_W - ADDR_W - LEN_W){1'b0}}, len, addr};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drops valid and waits until every predicted result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   // Packet length register; only called once the filter is drained.
   task automatic write_packet_length(input logic [LEN_W-1:0] len);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_len = len;
   endtask

   // Mostly well-formed packets; some ticks and some off-length frames.
   task automatic random_item();
      int unsigned       pick;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      pick = $urandom_range(99);
      if ($urandom_range(1) == 0)
         addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
      else
         addr = fresh_addr();
      if ($urandom_range(9) == 0)
         addr_pool[$urandom_range(POOL_SIZE - 1)] = fresh_addr();
      len = (pick < 20) ? LEN_W'($urandom_range(127)) : cur_len;
      send_item((pick < 5) ? ACT_TICK : ACT_FRAME, addr, len);
   endtask

   initial begin
      int unsigned phase;
      int unsigned n;

      for (n = 0; n < POOL_SIZE; n++)
         addr_pool[n] = fresh_addr();
      addr_pool[0] = ADDR_ZERO;
      addr_pool[1] = ADDR_ONES;

      set_idling(0);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset packet length ---
      send_item(ACT_FRAME, ADDR_ZERO, 7'd16);  // empty table, stored
      send_item(ACT_FRAME, ADDR_ZERO, 7'd16);  // hit in slot 0
      send_item(ACT_FRAME, ADDR_ONES, 7'd16);
      send_item(ACT_FRAME, ADDR_ONES, 7'd16);  // hit in last slot
      send_item(ACT_FRAME, ADDR_ZERO, 7'd16);
      send_item(ACT_FRAME, ADDR_ALTA, 7'd0);   // off-length frames are ignored
      send_item(ACT_FRAME, ADDR_ALT5, 7'd127);
      send_item(ACT_FRAME, ADDR_ALTA, 7'd15);
      send_item(ACT_TICK,  ADDR_ONES, 7'd16);  // tick clears the fill count
      send_item(ACT_FRAME, ADDR_ONES, 7'd16);  // forwarded again after the clear
      send_item(ACT_FRAME, ADDR_ALTA, 7'd16);
      send_item(ACT_FRAME, ADDR_ALT5, 7'd16);
      send_item(ACT_FRAME, ADDR_ALTA, 7'd16);

      // --- directed, length extremes; table carries over ---
      write_packet_length(7'd1);
      send_item(ACT_FRAME, ADDR_ZERO, 7'd1);
      send_item(ACT_FRAME, ADDR_ZERO, 7'd1);
      send_item(ACT_FRAME, ADDR_ONES, 7'd0);
      send_item(ACT_FRAME, ADDR_ONES, 7'd16);
      write_packet_length(7'd127);
      send_item(ACT_FRAME, ADDR_ALT5, 7'd127);
      send_item(ACT_FRAME, 64'h0123_4567_89AB_CDEF, 7'd127);
      send_item(ACT_FRAME, 64'h0123_4567_89AB_CDEF, 7'd127);
      send_item(ACT_FRAME, ADDR_ALTA, 7'd126);
      send_item(ACT_TICK,  ADDR_ZERO, 7'd127);
      send_item(ACT_FRAME, ADDR_ZERO, 7'd127);

      // --- random phases, one per idling mode ---
      for (phase = 0; phase < 3; phase++) begin
         set_idling(phase);
         case (phase)
            0:       write_packet_length(LEN_W'($urandom_range(2, 126)));
            1:       write_packet_length(7'd127);
            default: write_packet_length(7'd1);
         endcase
         if (phase == 0) begin
            // fill the table past its end so the store wraps to slot 0
            send_item(ACT_TICK, fresh_addr(), cur_len);
            for (n = 0; n < BURST_LEN; n++) begin
               burst_addr[n] = fresh_addr();
               send_item(ACT_FRAME, burst_addr[n], cur_len);
            end
            // only those stored since the wrap still hit; the rest were overwritten or lie past the fill count
            for (n = 0; n < 10; n++)
               send_item(ACT_FRAME, burst_addr[$urandom_range(BURST_LEN - 1)], cur_len);
         end
         for (n = 0; n < PHASE_ITEMS; n++)
            random_item();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== flood_duplicate_filter.f =====
src/fdf_pkg.sv
src/fdf_table.sv
src/fdf_ctrl.sv
src/flood_duplicate_filter.sv
src/fdf_checker.sv
tb/sv/flood_duplicate_filter_checker.sv
tb/sv/tb_flood_duplicate_filter.sv
